// ===== src/hpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-space projection package
// Shared constants, state type and a fixed-point helper.
// ----------------------------------------------------------------------------
package hpp_pkg;

  localparam int MAX_PLANES = 16;
  localparam int IDX_W      = $clog2(MAX_PLANES);
  localparam int CNT_W      = $clog2(MAX_PLANES + 1);
  localparam int DIV_STEPS  = 31;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] CFG_PLANE_COUNT = 2'd0;
  localparam logic [1:0] CFG_MAX_ITER    = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE   = 2'd2;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_PROJECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDOT,
    ST_TCHK,
    ST_PDOT,
    ST_PCHK,
    ST_NDOT,
    ST_NCHK,
    ST_DIV,
    ST_STEP,
    ST_OUT
  } state_e;

  // Q16.16 product rescale: divide by 65536, truncating toward zero.
  function automatic logic signed [63:0] q_trunc(input logic signed [63:0] prod);
    logic signed [63:0] sh;
    sh = prod >>> 16;
    if (prod[63] && (prod[15:0] != 16'd0)) begin
      sh = sh + 64'sd1;
    end
    return sh;
  endfunction

endpackage

// ===== src/halfspace_polytope_projection.sv =====
// ----------------------------------------------------------------------------
// Half-space polytope projection
// Plane table, inside test and cyclic Kaczmarz projection of a 3-D point.
// ----------------------------------------------------------------------------
// One request is handled at a time. A plane write goes from idle straight to
// the output register. A project request runs on one shared 32x32 multiplier
// and one compare-subtract unit for the division under a small sequencer: the
// inside test takes a dot product and a check per active plane, and each sweep
// takes a dot product and a check per satisfied plane, adds a norm dot product
// and check per degenerate plane, and for a violated plane adds a restoring
// division and an update, or skips the division when the ratio clamps.
// The result then waits in the output register until taken, and
// s_axis_tready is low meanwhile.
module halfspace_polytope_projection
  import hpp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // plane_index[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68],
  // plane_bound[131:100], zero fill to 136 bits
  input  logic [135:0] s_axis_tdata,
  // action[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], was_inside[96], saturated[97],
  // zero fill to 104 bits
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [4:0]  plane_count_q;
  logic [7:0]  max_iter_q;
  logic [30:0] tolerance_q;

  // Plane table.
  logic signed [31:0] nx_q [MAX_PLANES];
  logic signed [31:0] ny_q [MAX_PLANES];
  logic signed [31:0] nz_q [MAX_PLANES];
  logic signed [31:0] bd_q [MAX_PLANES];

  // Working point and flags.
  logic signed [31:0] p_q [3];
  logic               inside_q;
  logic               sat_q;

  // Sequencer counters.
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic [7:0]        iter_q;
  logic              acted_q;
  logic [1:0]        k_q;
  logic [DCNT_W-1:0] dcnt_q;

  // Arithmetic registers.
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] v_q;
  logic [63:0]        den_q;
  logic [63:0]        rem_q;
  logic [30:0]        num_q;
  logic [30:0]        t_q;

  logic signed [31:0] n_sel [3];
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] qt;
  logic signed [63:0] viol;
  logic signed [63:0] upd;
  logic [63:0]        trial;
  logic [IDX_W-1:0]   ti;
  logic [CNT_W-1:0]   count_in;
  logic               last_plane;
  logic               plane_done;
  logic               acted_now;
  logic               sweep_stop;
  logic               big_quot;

  assign ti       = idx_q[IDX_W-1:0];
  assign n_sel[0] = nx_q[ti];
  assign n_sel[1] = ny_q[ti];
  assign n_sel[2] = nz_q[ti];

  // Shared multiplier: the normal against the point, itself or the ratio.
  always_comb begin
    mul_a = n_sel[k_q[1] ? 2 : (k_q[0] ? 1 : 0)];
    case (state_q)
      ST_NDOT: mul_b = mul_a;
      ST_STEP: mul_b = $signed({1'b0, t_q});
      default: mul_b = p_q[k_q[1] ? 2 : (k_q[0] ? 1 : 0)];
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign qt    = q_trunc(prod_q);

  assign viol     = acc_q - 64'(bd_q[ti]);
  assign big_quot = 64'(v_q) >= (acc_q[63:0] << 15);
  assign trial    = {rem_q[62:0], num_q[30]};
  assign upd      = 64'(p_q[k_q - 2'd1]) - qt;

  assign count_in = (plane_count_q > 5'(MAX_PLANES)) ? CNT_W'(MAX_PLANES)
                                                      : CNT_W'(plane_count_q);
  assign last_plane = (idx_q + CNT_W'(1)) == count_q;
  assign plane_done = (state_q == ST_PCHK && viol <= 64'sd0) ||
                      (state_q == ST_NCHK && acc_q == 64'sd0) ||
                      (state_q == ST_STEP && k_q == 2'd3);
  assign acted_now  = acted_q || (state_q == ST_STEP);
  assign sweep_stop = !acted_now || ((iter_q + 8'd1) == max_iter_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == ACT_WRITE || count_in == '0) state_d = ST_OUT;
          else state_d = ST_TDOT;
        end
      end
      ST_TDOT: if (k_q == 2'd3) state_d = ST_TCHK;
      ST_TCHK: begin
        if (!last_plane) state_d = ST_TDOT;
        else if (max_iter_q == 8'd0) state_d = ST_OUT;
        else state_d = ST_PDOT;
      end
      ST_PDOT: if (k_q == 2'd3) state_d = ST_PCHK;
      ST_PCHK: if (viol > 64'sd0) state_d = ST_NDOT;
      ST_NDOT: if (k_q == 2'd3) state_d = ST_NCHK;
      ST_NCHK: begin
        if (acc_q != 64'sd0) state_d = big_quot ? ST_STEP : ST_DIV;
      end
      ST_DIV:  if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = ST_STEP;
      ST_STEP: ;
      ST_OUT:  if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (plane_done) begin
      state_d = (last_plane && sweep_stop) ? ST_OUT : ST_PDOT;
    end
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
    m_axis_tdata  = {6'd0, sat_q, inside_q, p_q[2], p_q[1], p_q[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      plane_count_q <= 5'd0;
      max_iter_q    <= 8'd20;
      tolerance_q   <= 31'd0;
      k_q           <= 2'd0;
      dcnt_q        <= '0;
      idx_q         <= '0;
      iter_q        <= 8'd0;
      acted_q       <= 1'b0;
      count_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PLANE_COUNT: plane_count_q <= cfg_data_i[4:0];
          CFG_MAX_ITER:    max_iter_q    <= cfg_data_i[7:0];
          CFG_TOLERANCE:   tolerance_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_TDOT || state_q == ST_PDOT || state_q == ST_NDOT ||
          state_q == ST_STEP) begin
        k_q <= k_q + 2'd1;
      end else begin
        k_q <= 2'd0;
      end
      dcnt_q <= (state_q == ST_DIV) ? dcnt_q + DCNT_W'(1) : '0;
      if (state_q == ST_IDLE) begin
        count_q <= count_in;
        idx_q   <= '0;
      end
      if (state_q == ST_TCHK) begin
        idx_q   <= last_plane ? '0 : idx_q + CNT_W'(1);
        iter_q  <= 8'd0;
        acted_q <= 1'b0;
      end
      if (plane_done) begin
        if (last_plane) begin
          idx_q   <= '0;
          iter_q  <= iter_q + 8'd1;
          acted_q <= 1'b0;
        end else begin
          idx_q   <= idx_q + CNT_W'(1);
          acted_q <= acted_now;
        end
      end
    end
  end

  // Datapath, payload only.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == ACT_WRITE) begin
            if (32'(s_axis_tdata[3:0]) < MAX_PLANES) begin
              nx_q[IDX_W'(s_axis_tdata[3:0])] <= s_axis_tdata[35:4];
              ny_q[IDX_W'(s_axis_tdata[3:0])] <= s_axis_tdata[67:36];
              nz_q[IDX_W'(s_axis_tdata[3:0])] <= s_axis_tdata[99:68];
              bd_q[IDX_W'(s_axis_tdata[3:0])] <= s_axis_tdata[131:100];
            end
            p_q[0]   <= 32'sd0;
            p_q[1]   <= 32'sd0;
            p_q[2]   <= 32'sd0;
            inside_q <= 1'b0;
          end else begin
            p_q[0]   <= s_axis_tdata[35:4];
            p_q[1]   <= s_axis_tdata[67:36];
            p_q[2]   <= s_axis_tdata[99:68];
            inside_q <= 1'b1;
          end
          sat_q <= 1'b0;
        end
      end
      ST_TDOT, ST_PDOT, ST_NDOT: begin
        acc_q <= (k_q == 2'd0) ? 64'sd0 : acc_q + qt;
      end
      ST_TCHK: begin
        if (acc_q > 64'(bd_q[ti]) + $signed({33'd0, tolerance_q})) inside_q <= 1'b0;
      end
      ST_PCHK: v_q <= viol;
      ST_NCHK: begin
        den_q <= acc_q;
        if (big_quot) begin
          t_q   <= 31'h7FFF_FFFF;
          if (acc_q != 64'sd0) sat_q <= 1'b1;
        end
        rem_q <= 64'(v_q) >> 15;
        num_q <= {v_q[14:0], 16'd0};
      end
      ST_DIV: begin
        if (trial >= den_q) begin
          rem_q <= trial - den_q;
          t_q   <= {t_q[29:0], 1'b1};
        end else begin
          rem_q <= trial;
          t_q   <= {t_q[29:0], 1'b0};
        end
        num_q <= {num_q[29:0], 1'b0};
      end
      ST_STEP: begin
        if (k_q != 2'd0) begin
          if (upd > 64'sd2147483647) begin
            p_q[k_q - 2'd1] <= 32'sh7FFF_FFFF;
            sat_q           <= 1'b1;
          end else if (upd < -64'sd2147483648) begin
            p_q[k_q - 2'd1] <= 32'sh8000_0000;
            sat_q           <= 1'b1;
          end else begin
            p_q[k_q - 2'd1] <= upd[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  // A division only runs against a nonzero denominator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> den_q != 64'd0)
    else $error("division started with zero denominator");

  // The plane cursor never leaves the active range while sweeping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PDOT || state_q == ST_TDOT) |-> idx_q < count_q)
    else $error("plane cursor out of range");

  // Sweeps never outrun the configured limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PDOT) |-> iter_q < max_iter_q)
    else $error("sweep count exceeded limit");

  // After the last update step the sequencer returns to the sweep or the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && k_q == 2'd3) |=> state_q == ST_PDOT || state_q == ST_OUT)
    else $error("update did not return to the sweep");

endmodule
